[src/bracket_balance_checker_defines.svh]
// assertion macros for the bracket balance checker port checks
// no dependencies; included by the checker module
`ifndef BRACKET_BALANCE_CHECKER_DEFINES_SVH
`define BRACKET_BALANCE_CHECKER_DEFINES_SVH

// same-cycle implication, disabled while reset is high
`define BBC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bbc check failed");

// next-cycle implication, disabled while reset is high
`define BBC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bbc check failed");

`endif

[src/bbc_pkg.sv]
// types, codes and character decoders for the bracket balance checker
// no dependencies; imported by every module of the block
`default_nettype none

package bbc_pkg;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } req_item_type;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] found_bracket;
      logic [7:0] closer_char;
      logic [6:0] nesting_depth;
   } rsp_item_type;

   typedef enum logic [2:0] {
      LEX_NORMAL = 3'd0,
      LEX_SLASH  = 3'd1,
      LEX_LINE   = 3'd2,
      LEX_BLOCK  = 3'd3,
      LEX_STAR   = 3'd4,
      LEX_QUOTE  = 3'd5,
      LEX_ESC    = 3'd6
   } lex_mode_type;

   // stack command from the lexer to the bracket stack
   typedef struct packed {
      logic       push;
      logic       pop;
      logic       clear;
      logic [1:0] code;
   } stack_cmd_type;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_MISMATCH  = 3'd1;
   localparam logic [2:0] ST_EMPTY     = 3'd2;
   localparam logic [2:0] ST_OVERFLOW  = 3'd3;
   localparam logic [2:0] ST_UNMATCHED = 3'd4;
   localparam logic [2:0] ST_CLEAN_END = 3'd5;

   localparam logic [1:0] CODE_NONE  = 2'd0;
   localparam logic [1:0] CODE_PAREN = 2'd1;
   localparam logic [1:0] CODE_SQUARE = 2'd2;
   localparam logic [1:0] CODE_CURLY = 2'd3;

   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_LSQUARE = 8'h5B;
   localparam logic [7:0] CH_RSQUARE = 8'h5D;
   localparam logic [7:0] CH_LCURLY  = 8'h7B;
   localparam logic [7:0] CH_RCURLY  = 8'h7D;
   localparam logic [7:0] CH_BSLASH  = 8'h5C;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_SQUOTE  = 8'h27;
   localparam logic [7:0] CH_DQUOTE  = 8'h22;

   function automatic logic [1:0] open_code(input logic [7:0] b);
      logic [1:0] code;
      unique case (b)
         CH_LPAREN:  code = CODE_PAREN;
         CH_LSQUARE: code = CODE_SQUARE;
         CH_LCURLY:  code = CODE_CURLY;
         default:    code = CODE_NONE;
      endcase
      return code;
   endfunction

   function automatic logic [1:0] close_code(input logic [7:0] b);
      logic [1:0] code;
      unique case (b)
         CH_RPAREN:  code = CODE_PAREN;
         CH_RSQUARE: code = CODE_SQUARE;
         CH_RCURLY:  code = CODE_CURLY;
         default:    code = CODE_NONE;
      endcase
      return code;
   endfunction

   function automatic logic [7:0] code_char(input logic [1:0] code);
      logic [7:0] ch;
      unique case (code)
         CODE_PAREN:  ch = CH_LPAREN;
         CODE_SQUARE: ch = CH_LSQUARE;
         CODE_CURLY:  ch = CH_LCURLY;
         default:     ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

`default_nettype wire

[src/bbc_stack.sv]
// bracket stack: top entry in a register, the rest in a memory with a
// registered prefetch of the entry below the top; uses bbc_pkg
`default_nettype none

module bbc_stack
   import bbc_pkg::*;
#(
   parameter int STACK_DEPTH = 64,
   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1,
   localparam int CW = $clog2(STACK_DEPTH + 1)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire stack_cmd_type cmd,
   output logic [CW-1:0]      count,
   output logic [CW-1:0]      next_count,
   output logic [1:0]         top_code
);

   logic [1:0]    mem [STACK_DEPTH];
   logic [CW-1:0] count_ff, count_in;
   logic [1:0]    top_ff, top_in;
   logic [1:0]    below_ff;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;

   always_comb begin
      count_in = count_ff;
      top_in   = top_ff;
      wr_en    = 1'b0;
      if (cmd.clear) begin
         count_in = '0;
      end else if (cmd.push) begin
         count_in = count_ff + CW'(1);
         top_in   = cmd.code;
         // old top moves down into the memory
         wr_en    = (count_ff != '0);
      end else if (cmd.pop) begin
         count_in = count_ff - CW'(1);
         top_in   = below_ff;
      end
   end

   assign wr_addr = AW'(count_ff - CW'(1));
   // always fetch the entry just below the next top
   assign rd_addr = AW'(count_in - CW'(2));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= top_ff;
      end
      if (wr_en && (wr_addr == rd_addr)) begin
         below_ff <= top_ff;
      end else begin
         below_ff <= mem[rd_addr];
      end
      top_ff <= top_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign count      = count_ff;
   assign next_count = count_in;
   assign top_code   = top_ff;

endmodule

`default_nettype wire

[src/bracket_balance_checker.sv]
// bracket balance checker top level: input register, lexer and result register
// depends on bbc_pkg and bbc_stack
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_item (req_item_type)
//   rsp      out        rsp_valid/rsp_stall  rsp_item (rsp_item_type)
//
// one item per cycle while rsp_stall is low; each item passes the input register, then the result register
// each item does one lexer step and at most one push, pop or clear on the bracket stack
// reset clears the valid flags, lexer mode and stack count; the stack memory itself is never cleared
// rsp_stall holds the result register, which then stalls the input register
`default_nettype none

module bracket_balance_checker
   import bbc_pkg::*;
#(
   parameter int STACK_DEPTH = 64
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_item_type req_item,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_item_type      rsp_item
);

   localparam int CW = $clog2(STACK_DEPTH + 1);

   logic          s1_valid_ff, s1_valid_in;
   req_item_type  s1_item_ff;
   logic          s1_fire;
   logic          out_ready;
   logic          req_take;

   lex_mode_type  lex_ff, lex_in;
   logic          quote_ff, quote_in;

   rsp_item_type  rsp_item_ff, result;
   logic          rsp_valid_ff;

   stack_cmd_type cmd;
   logic [CW-1:0] count;
   logic [CW-1:0] next_count;
   logic [1:0]    top_code;

   logic [7:0]    b;
   logic          eot;
   logic          normal_ok;
   logic [1:0]    opn;
   logic [1:0]    cls;
   logic          full;

   // handshake
   assign out_ready   = !rsp_valid_ff || !rsp_stall;
   assign s1_fire     = s1_valid_ff && out_ready;
   assign req_stall   = s1_valid_ff && !out_ready;
   assign req_take    = req_valid && !req_stall;
   assign s1_valid_in = req_take || (s1_valid_ff && !s1_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_take) begin
         s1_item_ff <= req_item;
      end
   end

   assign b   = s1_item_ff.text_byte;
   assign eot = s1_item_ff.end_of_text;

   // the byte is handled as code in normal mode, or after a slash that opened nothing
   assign normal_ok = (lex_ff == LEX_NORMAL) ||
                      ((lex_ff == LEX_SLASH) && (b != CH_SLASH) && (b != CH_STAR));
   assign opn  = open_code(b);
   assign cls  = close_code(b);
   assign full = (count == CW'(STACK_DEPTH));

   // lexer next state
   always_comb begin
      lex_in   = lex_ff;
      quote_in = quote_ff;
      if (s1_fire) begin
         if (eot) begin
            lex_in   = LEX_NORMAL;
            quote_in = 1'b0;
         end else if (normal_ok) begin
            if (b == CH_SLASH) begin
               lex_in = LEX_SLASH;
            end else if ((b == CH_SQUOTE) || (b == CH_DQUOTE)) begin
               lex_in   = LEX_QUOTE;
               quote_in = (b == CH_DQUOTE);
            end else begin
               lex_in = LEX_NORMAL;
            end
         end else begin
            unique case (lex_ff)
               LEX_SLASH: begin
                  lex_in = (b == CH_SLASH) ? LEX_LINE : LEX_BLOCK;
               end
               LEX_LINE: begin
                  if (b == CH_NEWLINE) lex_in = LEX_NORMAL;
               end
               LEX_BLOCK: begin
                  if (b == CH_STAR) lex_in = LEX_STAR;
               end
               LEX_STAR: begin
                  if (b == CH_SLASH) begin
                     lex_in = LEX_NORMAL;
                  end else if (b != CH_STAR) begin
                     lex_in = LEX_BLOCK;
                  end
               end
               LEX_QUOTE: begin
                  if (b == CH_BSLASH) begin
                     lex_in = LEX_ESC;
                  end else if (b == (quote_ff ? CH_DQUOTE : CH_SQUOTE)) begin
                     lex_in = LEX_NORMAL;
                  end
               end
               LEX_ESC: begin
                  lex_in = LEX_QUOTE;
               end
               default: begin
                  lex_in = LEX_NORMAL;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lex_ff   <= LEX_NORMAL;
         quote_ff <= 1'b0;
      end else begin
         lex_ff   <= lex_in;
         quote_ff <= quote_in;
      end
   end

   // lexer outputs: stack command and result fields
   always_comb begin
      cmd                  = '0;
      cmd.code             = opn;
      result.status        = ST_OK;
      result.found_bracket = 8'h00;
      result.closer_char   = 8'h00;
      if (eot) begin
         cmd.clear = s1_fire;
         if (count != '0) begin
            result.status        = ST_UNMATCHED;
            result.found_bracket = code_char(top_code);
         end else begin
            result.status = ST_CLEAN_END;
         end
      end else if (normal_ok) begin
         if (opn != CODE_NONE) begin
            if (full) begin
               result.status        = ST_OVERFLOW;
               result.found_bracket = code_char(top_code);
            end else begin
               cmd.push = s1_fire;
            end
         end else if (cls != CODE_NONE) begin
            if (count == '0) begin
               result.status      = ST_EMPTY;
               result.closer_char = b;
            end else if (top_code == cls) begin
               cmd.pop = s1_fire;
            end else begin
               result.status        = ST_MISMATCH;
               result.found_bracket = code_char(top_code);
               result.closer_char   = b;
            end
         end
      end
      result.nesting_depth = 7'(next_count);
   end

   bbc_stack #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .count      (count),
      .next_count (next_count),
      .top_code   (top_code)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (s1_fire) begin
         rsp_item_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

`default_nettype wire

[src/bbc_checker.sv]
// port-level checks for the bracket balance checker, bound to the top level
// depends on bbc_pkg and bracket_balance_checker_defines.svh
`default_nettype none
`include "bracket_balance_checker_defines.svh"

module bbc_checker
   import bbc_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_valid,
   input wire logic         req_stall,
   input wire req_item_type req_item,
   input wire logic         rsp_valid,
   input wire logic         rsp_stall,
   input wire rsp_item_type rsp_item
);

   logic req_take;
   assign req_take = req_valid && !req_stall && (req_item.text_byte == req_item.text_byte);

   // a stalled result stays put
   `BBC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_item))

   // an end item always leaves an empty stack behind
   `BBC_ASSERT_NOW(a_end_depth, clock, reset, rsp_valid && ((rsp_item.status == ST_UNMATCHED) || (rsp_item.status == ST_CLEAN_END)), rsp_item.nesting_depth == 7'd0)

   // quiet results carry no characters
   `BBC_ASSERT_NOW(a_quiet_zero, clock, reset, rsp_valid && ((rsp_item.status == ST_OK) || (rsp_item.status == ST_CLEAN_END)), (rsp_item.found_bracket == 8'h00) && (rsp_item.closer_char == 8'h00))

   // a mismatch names both the open bracket and the closer
   `BBC_ASSERT_NOW(a_mismatch_chars, clock, reset, rsp_valid && (rsp_item.status == ST_MISMATCH), (rsp_item.found_bracket != 8'h00) && (rsp_item.closer_char != 8'h00))

   // with nothing pending, an accepted item reaches rsp through the input and result registers
   `BBC_ASSERT_NEXT(a_latency, clock, reset, req_take && !rsp_valid && !rsp_stall, ##1 rsp_valid)

endmodule

bind bracket_balance_checker bbc_checker u_bbc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_item  (req_item),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_item  (rsp_item)
);

`default_nettype wire

[bench/tb.sv]
// testbench for bracket_balance_checker: directed, overflow and random text items
// predicts each report from its own lexer and stack, checks in order; needs bbc_pkg
`timescale 1ns / 100ps

module tb;
   import bbc_pkg::*;

   localparam int STACK_DEPTH  = 64;
   localparam int ITEM_TARGET  = 1850;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 8;

   localparam int STALL_NONE   = 0;
   localparam int STALL_RANDOM = 1;
   localparam int STALL_SPARSE = 2;
   localparam int STALL_BURSTS = 3;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_item = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_item;

   bracket_balance_checker #(.STACK_DEPTH(STACK_DEPTH)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predicted lexer and bracket stack
   lex_mode_type scan_mode = LEX_NORMAL;
   logic         in_dquote = 1'b0;
   logic [1:0]   open_stack [STACK_DEPTH];
   int unsigned  open_count = 0;
   int unsigned  deepest = 0;

   rsp_item_type expected_reports [$];
   rsp_item_type oldest_report;
   int           mismatch_count = 0;
   int           items_sent = 0;
   int           reports_checked = 0;
   int           status_seen [8] = '{default: 0};
   int           cycle_count = 0;

   logic         sender_active = 1'b0;
   int           burst_left = 0;
   int           gap_len;
   int           stall_mode = STALL_NONE;
   int           stall_left = 0;

   function automatic logic [7:0] opener_char(input logic [1:0] code);
      case (code)
         CODE_PAREN:  return CH_LPAREN;
         CODE_SQUARE: return CH_LSQUARE;
         CODE_CURLY:  return CH_LCURLY;
         default:     return 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] closer_for(input logic [1:0] code);
      case (code)
         CODE_PAREN:  return CH_RPAREN;
         CODE_SQUARE: return CH_RSQUARE;
         CODE_CURLY:  return CH_RCURLY;
         default:     return 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] top_bracket();
      if (open_count == 0) return 8'h00;
      return opener_char(open_stack[open_count - 1]);
   endfunction

   // one byte seen in plain code
   function automatic void code_byte(input logic [7:0] b, inout rsp_item_type r);
      logic [1:0] op;
      logic [1:0] cl;
      op = CODE_NONE;
      cl = CODE_NONE;
      if (b == CH_SLASH) begin
         scan_mode = LEX_SLASH;
         return;
      end
      if (b == CH_SQUOTE || b == CH_DQUOTE) begin
         in_dquote = (b == CH_DQUOTE);
         scan_mode = LEX_QUOTE;
         return;
      end
      case (b)
         CH_LPAREN:  op = CODE_PAREN;
         CH_LSQUARE: op = CODE_SQUARE;
         CH_LCURLY:  op = CODE_CURLY;
         CH_RPAREN:  cl = CODE_PAREN;
         CH_RSQUARE: cl = CODE_SQUARE;
         CH_RCURLY:  cl = CODE_CURLY;
         default:    ;
      endcase
      if (op != CODE_NONE) begin
         if (open_count >= STACK_DEPTH) begin
            r.status = ST_OVERFLOW;
            r.found_bracket = top_bracket();
         end else begin
            open_stack[open_count] = op;
            open_count++;
         end
      end else if (cl != CODE_NONE) begin
         if (open_count == 0) begin
            r.status = ST_EMPTY;
            r.closer_char = b;
         end else if (open_stack[open_count - 1] == cl) begin
            open_count--;
         end else begin
            r.status = ST_MISMATCH;
            r.found_bracket = top_bracket();
            r.closer_char = b;
         end
      end
   endfunction

   function automatic rsp_item_type bracket_step(input req_item_type it);
      rsp_item_type r;
      logic [7:0]   b;
      r = '0;
      b = it.text_byte;
      if (it.end_of_text) begin
         if (open_count != 0) begin
            r.status = ST_UNMATCHED;
            r.found_bracket = top_bracket();
         end else begin
            r.status = ST_CLEAN_END;
         end
         scan_mode = LEX_NORMAL;
         in_dquote = 1'b0;
         open_count = 0;
      end else begin
         case (scan_mode)
            LEX_SLASH: begin
               if (b == CH_SLASH) scan_mode = LEX_LINE;
               else if (b == CH_STAR) scan_mode = LEX_BLOCK;
               else begin
                  scan_mode = LEX_NORMAL;
                  code_byte(b, r);
               end
            end
            LEX_LINE: begin
               if (b == CH_NEWLINE) scan_mode = LEX_NORMAL;
            end
            LEX_BLOCK: begin
               if (b == CH_STAR) scan_mode = LEX_STAR;
            end
            LEX_STAR: begin
               if (b == CH_SLASH) scan_mode = LEX_NORMAL;
               else if (b != CH_STAR) scan_mode = LEX_BLOCK;
            end
            LEX_QUOTE: begin
               if (b == CH_BSLASH) scan_mode = LEX_ESC;
               else if (b == (in_dquote ? CH_DQUOTE : CH_SQUOTE)) scan_mode = LEX_NORMAL;
            end
            LEX_ESC: scan_mode = LEX_QUOTE;
            default: begin
               scan_mode = LEX_NORMAL;
               code_byte(b, r);
            end
         endcase
      end
      if (open_count > deepest) deepest = open_count;
      r.nesting_depth = 7'(open_count);
      return r;
   endfunction

   function automatic logic [7:0] pick_char(input string s);
      return s[$urandom_range(0, s.len() - 1)];
   endfunction

   // sends one item; the sender runs in bursts with random gaps between them
   task automatic send_text(input logic [7:0] b, input logic eot);
      req_item_type it;
      it.text_byte = b;
      it.end_of_text = eot;
      req_item <= it;
      req_valid <= 1'b1;
      sender_active = 1'b1;
      do @(posedge clock); while (req_stall);
      expected_reports.push_back(bracket_step(it));
      items_sent++;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                 : $urandom_range(1, 40);
         gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap_len != 0) begin
            req_valid <= 1'b0;
            sender_active = 1'b0;
            repeat (gap_len) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   task automatic send_string(input string s);
      for (int i = 0; i < s.len(); i++) send_text(s[i], 1'b0);
   endtask

   // hold the sender until every predicted report has come back
   task automatic drain_reports();
      if (sender_active) begin
         req_valid <= 1'b0;
         sender_active = 1'b0;
      end
      while (expected_reports.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed_cases();
      send_text(8'h00, 1'b0);
      send_text(8'hFF, 1'b0);
      send_text(CH_RPAREN, 1'b0);      // closer on empty stack
      send_string("{/(");              // slash then opener still pushes
      send_string("/**/]");            // shortest block comment, then mismatch on paren
      send_string("\"\\\"]\"");        // escaped quote, bracket inside literal ignored
      send_string("//)\n");            // bracket inside line comment ignored
      send_text(CH_RPAREN, 1'b0);
      send_string("/*");
      send_text(8'hFF, 1'b1);          // end inside comment with curly still open
      send_text(8'h00, 1'b1);          // clean end
   endtask

   task automatic test_stack_overflow();
      send_text(8'h00, 1'b1);
      for (int i = 0; i < STACK_DEPTH; i++) send_text(pick_char("([{"), 1'b0);
      send_text(CH_LSQUARE, 1'b0);
      send_text(CH_LCURLY, 1'b0);
      send_text(closer_for(open_stack[STACK_DEPTH - 1] == CODE_PAREN ? CODE_CURLY : CODE_PAREN),
                1'b0);
      send_text(closer_for(open_stack[STACK_DEPTH - 1]), 1'b0);
      send_text(CH_LPAREN, 1'b0);
      send_text(CH_LPAREN, 1'b0);
      send_text(8'h5A, 1'b1);
   endtask

   task automatic test_random_text();
      int         roll;
      logic [7:0] quote_char;
      while (items_sent < ITEM_TARGET) begin
         // mostly steer back to plain code so brackets get exercised
         if (scan_mode != LEX_NORMAL && $urandom_range(0, 3) != 0) begin
            case (scan_mode)
               LEX_LINE:            send_text(CH_NEWLINE, 1'b0);
               LEX_BLOCK, LEX_STAR: send_string("*/");
               LEX_QUOTE:           send_text(in_dquote ? CH_DQUOTE : CH_SQUOTE, 1'b0);
               default:             send_text(pick_char("a; "), 1'b0);
            endcase
            continue;
         end
         roll = $urandom_range(0, 99);
         if (roll < 25) begin
            send_text(pick_char("([{"), 1'b0);
         end else if (roll < 55) begin
            if (open_count != 0 && $urandom_range(0, 6) != 0)
               send_text(closer_for(open_stack[open_count - 1]), 1'b0);
            else
               send_text(pick_char(")]}"), 1'b0);
         end else if (roll < 64) begin
            repeat ($urandom_range(1, 6)) send_text(pick_char("ab_x1 ;=+\n\t"), 1'b0);
         end else if (roll < 71) begin
            send_string("//");
            repeat ($urandom_range(0, 8)) send_text(pick_char("ab ({[)]}*/'\""), 1'b0);
            send_text(CH_NEWLINE, 1'b0);
         end else if (roll < 78) begin
            send_string("/*");
            repeat ($urandom_range(0, 8)) send_text(pick_char("ab *{(}]\n'\""), 1'b0);
            repeat ($urandom_range(1, 3)) send_text(CH_STAR, 1'b0);
            send_text(CH_SLASH, 1'b0);
         end else if (roll < 86) begin
            quote_char = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
            send_text(quote_char, 1'b0);
            repeat ($urandom_range(0, 6)) begin
               if ($urandom_range(0, 3) == 0) begin
                  send_text(CH_BSLASH, 1'b0);
                  send_text(8'($urandom_range(0, 255)), 1'b0);
               end else begin
                  send_text(pick_char("ab ()[]{}/*\n"), 1'b0);
               end
            end
            send_text(quote_char, 1'b0);
         end else if (roll < 91) begin
            send_text(8'($urandom_range(0, 255)), 1'b0);
         end else if (roll < 94) begin
            send_text(8'($urandom_range(0, 255)), 1'b1);
         end else if (roll < 97) begin
            // text cut off after a slash or in the middle of a comment or literal
            case ($urandom_range(0, 4))
               0:       send_text(CH_SLASH, 1'b0);
               1:       send_string("/*x*");
               2:       send_string("//(");
               3:       send_string("'\\");
               default: send_string("\"[");
            endcase
            send_text(8'($urandom_range(0, 255)), 1'b1);
         end else if (roll < 99) begin
            send_text(CH_SLASH, 1'b0);
            send_text(8'($urandom_range(0, 255)), 1'b0);
         end else begin
            repeat ($urandom_range(40, 70)) send_text(pick_char("([{"), 1'b0);
         end
      end
   endtask

   // receiver stall pattern, mode changes when its random hold count runs out
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(STALL_NONE, STALL_BURSTS);
         stall_left <= $urandom_range(16, 160);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         STALL_RANDOM: rsp_stall <= ($urandom_range(0, 1) == 1);
         STALL_SPARSE: rsp_stall <= ($urandom_range(0, 5) == 0);
         STALL_BURSTS: rsp_stall <= ((stall_left % 16) < 6);
         default:      rsp_stall <= 1'b0;
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_reports.size() == 0) begin
            $error("report with none expected: status %0d", rsp_item.status);
            mismatch_count++;
         end else begin
            oldest_report = expected_reports.pop_front();
            reports_checked++;
            status_seen[oldest_report.status]++;
            if (rsp_item.status !== oldest_report.status) begin
               $error("status: expected %0d, actual %0d", oldest_report.status, rsp_item.status);
               mismatch_count++;
            end
            if (rsp_item.found_bracket !== oldest_report.found_bracket) begin
               $error("found_bracket: expected %0h, actual %0h",
                      oldest_report.found_bracket, rsp_item.found_bracket);
               mismatch_count++;
            end
            if (rsp_item.closer_char !== oldest_report.closer_char) begin
               $error("closer_char: expected %0h, actual %0h",
                      oldest_report.closer_char, rsp_item.closer_char);
               mismatch_count++;
            end
            if (rsp_item.nesting_depth !== oldest_report.nesting_depth) begin
               $error("nesting_depth: expected %0d, actual %0d",
                      oldest_report.nesting_depth, rsp_item.nesting_depth);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d reports outstanding",
                  cycle_count, expected_reports.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      drain_reports();
      test_stack_overflow();
      drain_reports();
      test_random_text();
      drain_reports();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("%0d items sent, %0d reports checked, deepest nesting %0d",
               items_sent, reports_checked, deepest);
      $display("mismatched %0d, empty-stack %0d, overflow %0d, open at end %0d, clean ends %0d",
               status_seen[ST_MISMATCH], status_seen[ST_EMPTY], status_seen[ST_OVERFLOW],
               status_seen[ST_UNMATCHED], status_seen[ST_CLEAN_END]);
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
